// File: sv/pifd_pkg.sv
// ----------------------------------------------------------------------------
// pifd_pkg
// Shared types and constants of the pulse interval frame decoder: register
// indexes, frame modes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pifd_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_FRAME_MODE    = 3'd0;
   localparam logic [2:0] REG_SYNC_GAP      = 3'd1;
   localparam logic [2:0] REG_BIT_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_VALID_MIN     = 3'd3;
   localparam logic [2:0] REG_VALID_MAX     = 3'd4;

   // frame modes
   localparam logic [1:0] MODE_CRC    = 2'd0;
   localparam logic [1:0] MODE_TRIPLE = 2'd1;
   localparam logic [1:0] MODE_TWICE  = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   // frame status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam int DATA_BITS  = 16;
   localparam int CHECK_BITS = 8;

   localparam logic [5:0] LEN_CRC    = 6'(DATA_BITS + CHECK_BITS);
   localparam logic [5:0] LEN_TRIPLE = 6'd24;
   localparam logic [5:0] LEN_TWICE  = 6'd32;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // scaled result numerator and divider geometry
   localparam int          DIV_BITS   = 21;
   localparam int          DIV_CNT_W  = $clog2(DIV_BITS);
   localparam logic [20:0] SCALE_NUM  = 21'(1100 * 1023);

   // reset values of the registers
   localparam logic [1:0]  RST_FRAME_MODE    = MODE_TWICE;
   localparam logic [31:0] RST_SYNC_GAP      = 32'd5000;
   localparam logic [31:0] RST_BIT_THRESHOLD = 32'd1500;
   localparam logic [15:0] RST_VALID_MIN     = 16'd1;
   localparam logic [15:0] RST_VALID_MAX     = 16'd65535;

   typedef struct packed {
      logic [1:0]  frame_mode;
      logic [31:0] sync_gap;
      logic [31:0] bit_threshold;
      logic [15:0] valid_min;
      logic [15:0] valid_max;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic crc_start;
      logic crc_step;
      logic check;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
      logic crc_mode;
      logic crc_last;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

// File: sv/pifd_csr.sv
// ----------------------------------------------------------------------------
// pifd_csr
// APB-style register file holding the frame decoder configuration.
// ----------------------------------------------------------------------------
module pifd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output pifd_pkg::cfg_type cfg
);
   import pifd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FRAME_MODE:    cfg_in.frame_mode    = pwdata[1:0];
            REG_SYNC_GAP:      cfg_in.sync_gap      = pwdata;
            REG_BIT_THRESHOLD: cfg_in.bit_threshold = pwdata;
            REG_VALID_MIN:     cfg_in.valid_min     = pwdata[15:0];
            REG_VALID_MAX:     cfg_in.valid_max     = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_MODE:    prdata = {30'd0, cfg_ff.frame_mode};
         REG_SYNC_GAP:      prdata = cfg_ff.sync_gap;
         REG_BIT_THRESHOLD: prdata = cfg_ff.bit_threshold;
         REG_VALID_MIN:     prdata = {16'd0, cfg_ff.valid_min};
         REG_VALID_MAX:     prdata = {16'd0, cfg_ff.valid_max};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode    <= RST_FRAME_MODE;
         cfg_ff.sync_gap      <= RST_SYNC_GAP;
         cfg_ff.bit_threshold <= RST_BIT_THRESHOLD;
         cfg_ff.valid_min     <= RST_VALID_MIN;
         cfg_ff.valid_max     <= RST_VALID_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/pifd_ctrl.sv
// ----------------------------------------------------------------------------
// pifd_ctrl
// Frame decoder sequencer: accepts an edge, lets the datapath evaluate it and,
// on a finished frame, steps the crc (crc mode), check, divider and output.
// ----------------------------------------------------------------------------
module pifd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pifd_pkg::sts_type sts,
   output pifd_pkg::cmd_type cmd
);
   import pifd_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EVAL  = 6'b000010,
      S_CRC   = 6'b000100,
      S_CHECK = 6'b001000,
      S_DIV   = 6'b010000,
      S_LOAD  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.frame_done && sts.crc_mode) begin
               cmd.crc_start = 1'b1;
               state_in      = S_CRC;
            end else if (sts.frame_done) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            if (sts.crc_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/pifd_datapath.sv
// ----------------------------------------------------------------------------
// pifd_datapath
// Interval and bit decoding, frame state, bit-serial crc, restoring divider
// for the scaled result and the output register.
// ----------------------------------------------------------------------------
module pifd_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pifd_pkg::cfg_type cfg,
   input  pifd_pkg::cmd_type cmd,
   output pifd_pkg::sts_type sts,
   input  logic [31:0]       req_edge_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_frame_status,
   output logic [15:0]       rsp_held_value,
   output logic [15:0]       rsp_scaled_result
);
   import pifd_pkg::*;

   // frame state
   logic [31:0] edge_ff;
   logic [31:0] prev_ff,   prev_in;
   logic        active_ff, active_in;
   logic [5:0]  pos_ff,    pos_in;
   logic [31:0] bits_ff,   bits_in;
   logic [7:0]  chk_ff,    chk_in;
   logic [15:0] acc_ff,    acc_in;
   logic [1:0]  status_ff, status_in;

   // crc engine
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_data_ff, crc_data_in;
   logic [3:0]  crc_cnt_ff, crc_cnt_in;

   // divider
   logic [15:0]          divisor_ff, divisor_in;
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [16:0]          rem_shift;
   logic                 rem_ge;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_held_ff;
   logic [15:0] rsp_scaled_ff;
   logic [15:0] scaled;

   logic [31:0] elapsed;
   logic        is_sync, is_one, bit_take;
   logic [1:0]  eff_mode;
   logic [5:0]  frame_len;
   logic [1:0]  verdict;
   logic [15:0] verdict_value;

   always_comb begin
      elapsed = edge_ff - prev_ff;
      is_sync = elapsed > cfg.sync_gap;
      is_one  = elapsed < cfg.bit_threshold;
      unique case (cfg.frame_mode)
         MODE_CRC:    eff_mode = MODE_CRC;
         MODE_TRIPLE: eff_mode = MODE_TRIPLE;
         MODE_TWICE:  eff_mode = MODE_TWICE;
         MODE_SPARE:  eff_mode = MODE_TWICE;
         default:     eff_mode = MODE_TWICE;
      endcase
      unique case (eff_mode)
         MODE_CRC:    frame_len = LEN_CRC;
         MODE_TRIPLE: frame_len = LEN_TRIPLE;
         default:     frame_len = LEN_TWICE;
      endcase
      bit_take = !is_sync && active_ff && (pos_ff < frame_len);
   end

   // frame verdict on the stored bits
   always_comb begin
      verdict       = STATUS_OK;
      verdict_value = 16'd0;
      unique case (eff_mode)
         MODE_CRC: begin
            verdict_value = bits_ff[15:0];
            if (chk_ff != crc_ff[7:0]) begin
               verdict = STATUS_MISMATCH;
            end
         end
         MODE_TRIPLE: begin
            verdict_value = {8'd0, bits_ff[7:0]};
            if (bits_ff[7:0] != bits_ff[15:8] || bits_ff[7:0] != bits_ff[23:16]) begin
               verdict = STATUS_MISMATCH;
            end
         end
         default: begin
            verdict_value = bits_ff[15:0];
            if (bits_ff[15:0] != bits_ff[31:16]) begin
               verdict = STATUS_MISMATCH;
            end else if (bits_ff[15:0] < cfg.valid_min || bits_ff[15:0] > cfg.valid_max) begin
               verdict = STATUS_RANGE;
            end
         end
      endcase
   end

   always_comb begin
      prev_in   = prev_ff;
      active_in = active_ff;
      pos_in    = pos_ff;
      bits_in   = bits_ff;
      chk_in    = chk_ff;
      if (cmd.eval) begin
         prev_in = edge_ff;
         if (is_sync) begin
            active_in = 1'b1;
            pos_in    = 6'd0;
            bits_in   = 32'd0;
            chk_in    = 8'd0;
         end else if (bit_take) begin
            // check byte starts on a byte boundary, so the low bits index it
            if (eff_mode == MODE_CRC && pos_ff >= 6'(DATA_BITS)) begin
               chk_in[pos_ff[2:0]] = chk_ff[pos_ff[2:0]] | is_one;
            end else begin
               bits_in[pos_ff[4:0]] = bits_ff[pos_ff[4:0]] | is_one;
            end
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   // crc: shift in the data MSB first, fold the polynomial on a carry out
   always_comb begin
      crc_in      = crc_ff;
      crc_data_in = crc_data_ff;
      crc_cnt_in  = crc_cnt_ff;
      if (cmd.crc_start) begin
         crc_in      = CRC_SEED;
         crc_data_in = bits_ff[15:0];
         crc_cnt_in  = 4'd0;
      end else if (cmd.crc_step) begin
         crc_in      = {crc_ff[14:0], crc_data_ff[15]} ^ (crc_ff[15] ? CRC_POLY : 16'd0);
         crc_data_in = {crc_data_ff[14:0], 1'b0};
         crc_cnt_in  = crc_cnt_ff + 4'd1;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      status_in = status_ff;
      if (cmd.check) begin
         status_in = verdict;
         if (verdict == STATUS_OK) begin
            acc_in = verdict_value;
         end
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_shift  = {rem_ff, quo_ff[DIV_BITS-1]};
      rem_ge     = rem_shift >= {1'b0, divisor_ff};
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.check) begin
         divisor_in = acc_in;
         rem_in     = 16'd0;
         quo_in     = SCALE_NUM;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = rem_ge ? 16'(rem_shift - {1'b0, divisor_ff}) : rem_shift[15:0];
         quo_in     = {quo_ff[DIV_BITS-2:0], rem_ge};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_comb begin
      if (divisor_ff == 16'd0) begin
         scaled = 16'd0;
      end else if (quo_ff[DIV_BITS-1:16] != '0) begin
         scaled = 16'hFFFF;
      end else begin
         scaled = quo_ff[15:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts.frame_done = bit_take && (6'(pos_ff + 6'd1) == frame_len);
      sts.crc_mode   = eff_mode == MODE_CRC;
      sts.crc_last   = crc_cnt_ff == 4'(DATA_BITS - 1);
      sts.div_last   = div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 32'd0;
         active_ff    <= 1'b0;
         pos_ff       <= 6'd0;
         bits_ff      <= 32'd0;
         chk_ff       <= 8'd0;
         acc_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         bits_ff      <= bits_in;
         chk_ff       <= chk_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         edge_ff <= req_edge_time;
      end
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_held_ff   <= acc_ff;
         rsp_scaled_ff <= scaled;
      end
      status_ff   <= status_in;
      crc_ff      <= crc_in;
      crc_data_ff <= crc_data_in;
      crc_cnt_ff  <= crc_cnt_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = rsp_status_ff;
   assign rsp_held_value    = rsp_held_ff;
   assign rsp_scaled_result = rsp_scaled_ff;

endmodule

// File: sv/pulse_interval_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// pulse_interval_frame_decoder_unit
// Decodes pulse-distance frames from falling-edge timestamps and reports the
// checked value together with its scaled reciprocal.
// ----------------------------------------------------------------------------
// An edge timestamp is accepted in the idle state and its interval decoded to a
// bit in the evaluate state; req_ready is then high again unless the edge
// finished a frame, which holds the input through the check, divide and load
// states in the byte-three-times and halfword-twice modes, and through the crc
// state too in the crc mode: the crc is worked one data bit a cycle and the
// reciprocal 1125300 / value comes from a restoring divider that yields one
// quotient bit a cycle. The result then sits in an output register while the
// next edges are taken; a new result waits only if the previous one has not
// been taken by then. Configuration writes complete in the usual setup and
// access cycles and should be done while no transaction is in flight.
module pulse_interval_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_edge_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_held_value,
   output logic [15:0] rsp_scaled_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pifd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   pifd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pifd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pifd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .sts               (sts),
      .req_edge_time     (req_edge_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_held_value    (rsp_held_value),
      .rsp_scaled_result (rsp_scaled_result)
   );

endmodule
